// ----- rtl/cen_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the 3x3 census transform.
// No dependencies; used by cen_line_store, census_transform_3x3, census_checker and the testbench.
package cen_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
   localparam int POS_BITS   = 12;
   localparam int SIZE_BITS  = 13;
   localparam int PIX_BITS   = 8;
   localparam int WIDTH_CAP  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [PIX_BITS-1:0]  pixel_type;
   typedef logic [POS_BITS-1:0]  pos_type;
   typedef logic [SIZE_BITS-1:0] size_type;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // write-back of one column into both line stores
   typedef struct packed {
      logic      en;
      addr_type  addr;
      pixel_type upper;
      pixel_type middle;
   } cen_wr_type;

   function automatic size_type clamp_size(input size_type value, input size_type cap);
      size_type result;
      result = value;
      if (value < SIZE_BITS'(3)) begin
         result = SIZE_BITS'(3);
      end else if (value > cap) begin
         result = cap;
      end
      return result;
   endfunction

   // column to store slot: saturate at the last entry
   function automatic addr_type col_to_slot(input pos_type col);
      addr_type result;
      if (int'(col) >= MAX_WIDTH) begin
         result = ADDR_BITS'(MAX_WIDTH - 1);
      end else begin
         result = ADDR_BITS'(col);
      end
      return result;
   endfunction

endpackage

// ----- rtl/census_transform_3x3.sv -----
`timescale 1ns / 1ps
// 3x3 census transform over a raster pixel stream. Uses cen_pkg, cen_line_store.
// The pixel that completes a window is registered in stage 1 with its line store reads; its
// code is formed from there and goes into the output register once that register is free.
// Throughput: one pixel per cycle unless the output stalls; each pixel takes one line store
// read and one write-back. Reset: sizes go to 640 x 480, position and window to zero; the
// line stores are not cleared, and codes of the first two rows and columns do not use them.
module census_transform_3x3
   import cen_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_pixel_value,
   input  logic              req_frame_start,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_census_code,
   output logic [11:0]       rsp_out_row,
   output logic [11:0]       rsp_out_col,
   output logic              rsp_frame_done,
   input  logic              csr_write_enable,
   input  csr_index_type     csr_index,
   input  logic [12:0]       csr_data
);

   size_type frame_width_ff;
   size_type frame_height_ff;
   size_type width_use;
   size_type height_use;

   pos_type col_ff, col_in;
   pos_type row_ff, row_in;
   pos_type col_cur;
   pos_type row_cur;
   size_type col_inc;
   size_type row_inc;

   logic      s1_valid_ff, s1_valid_in;
   pixel_type s1_pix_ff;
   pos_type   s1_col_ff;
   pos_type   s1_row_ff;
   addr_type  s1_slot_ff;
   logic      s1_emit_ff;
   logic      s1_code_en_ff;
   logic      s1_done_ff;

   pixel_type win_ff [6];
   pixel_type up_rd;
   pixel_type mid_rd;
   pixel_type nb [8];
   logic [7:0] code;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_code_ff;
   pos_type    rsp_row_ff;
   pos_type    rsp_col_ff;
   logic       rsp_done_ff;

   logic       accept;
   logic       out_free;
   logic       s1_fire;
   cen_wr_type wr;

   assign width_use  = clamp_size(frame_width_ff, SIZE_BITS'(WIDTH_CAP));
   assign height_use = clamp_size(frame_height_ff, SIZE_BITS'(4096));

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= SIZE_BITS'(640);
         frame_height_ff <= SIZE_BITS'(480);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // position of this pixel and of the next one
   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      col_inc = {1'b0, col_cur} + SIZE_BITS'(1);
      row_inc = {1'b0, row_cur} + SIZE_BITS'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_inc >= width_use) begin
            col_in = '0;
            row_in = (row_inc >= height_use) ? '0 : row_inc[POS_BITS-1:0];
         end else begin
            col_in = col_inc[POS_BITS-1:0];
            row_in = row_cur;
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff     <= req_pixel_value;
         s1_col_ff     <= col_cur;
         s1_row_ff     <= row_cur;
         s1_slot_ff    <= col_to_slot(col_cur);
         s1_emit_ff    <= (row_cur != '0) && (col_cur != '0);
         s1_code_en_ff <= (row_cur >= POS_BITS'(2)) && (col_cur >= POS_BITS'(2));
         s1_done_ff    <= ({1'b0, row_cur} == height_use - SIZE_BITS'(1)) &&
                          ({1'b0, col_cur} == width_use - SIZE_BITS'(1));
      end
   end

   // the row one back moves up, the new pixel becomes the row one back
   assign wr.en     = s1_fire;
   assign wr.addr   = s1_slot_ff;
   assign wr.upper  = mid_rd;
   assign wr.middle = s1_pix_ff;

   cen_line_store u_line_store (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (col_to_slot(col_cur)),
      .wr        (wr),
      .rd_upper  (up_rd),
      .rd_middle (mid_rd)
   );

   // neighbours in bit order; centre is win_ff[3]
   always_comb begin
      nb[0] = win_ff[0];
      nb[1] = win_ff[1];
      nb[2] = up_rd;
      nb[3] = win_ff[2];
      nb[4] = mid_rd;
      nb[5] = win_ff[4];
      nb[6] = win_ff[5];
      nb[7] = s1_pix_ff;
      for (int i = 0; i < 8; i++) begin
         code[i] = s1_code_en_ff && (nb[i] < win_ff[3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= up_rd;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= mid_rd;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= s1_pix_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_fire && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_emit_ff) begin
         rsp_code_ff <= code;
         rsp_row_ff  <= s1_row_ff - POS_BITS'(1);
         rsp_col_ff  <= s1_col_ff - POS_BITS'(1);
         rsp_done_ff <= s1_done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_census_code = rsp_code_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_frame_done  = rsp_done_ff;

   // input held back only while a pixel is waiting for the output register
   a_stall_needs_s1: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with stage 1 empty");

   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_emit_ff) |=> rsp_valid_ff)
      else $error("emitted code lost");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_row_ff == '0) || (rsp_col_ff == '0))) |->
      (rsp_code_ff == '0))
      else $error("border code not zero");

endmodule

// ----- rtl/cen_line_store.sv -----
`timescale 1ns / 1ps
// Two line stores (row two back, row one back) with registered read.
// Forwards a write-back that hits the address read in the same cycle. Uses cen_pkg.
module cen_line_store
   import cen_pkg::*;
(
   input  logic       clock,
   input  logic       rd_en,
   input  addr_type   rd_addr,
   input  cen_wr_type wr,
   output pixel_type  rd_upper,
   output pixel_type  rd_middle
);

   pixel_type upper_mem [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];

   pixel_type upper_rd_ff;
   pixel_type middle_rd_ff;
   logic      hit_ff;
   pixel_type fwd_upper_ff;
   pixel_type fwd_middle_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         upper_mem[wr.addr]  <= wr.upper;
         middle_mem[wr.addr] <= wr.middle;
      end
   end

   // read sees old data on a same-address write; keep the new data aside
   always_ff @(posedge clock) begin
      if (rd_en) begin
         upper_rd_ff   <= upper_mem[rd_addr];
         middle_rd_ff  <= middle_mem[rd_addr];
         hit_ff        <= wr.en && (wr.addr == rd_addr);
         fwd_upper_ff  <= wr.upper;
         fwd_middle_ff <= wr.middle;
      end
   end

   assign rd_upper  = hit_ff ? fwd_upper_ff  : upper_rd_ff;
   assign rd_middle = hit_ff ? fwd_middle_ff : middle_rd_ff;

endmodule

// ----- sim/census_checker.sv -----
`timescale 1ns / 1ps
// Checker for census_transform_3x3: follows both channels and the register port, predicts the
// census code of each transfer past row 0 and column 0 and compares in order. Uses cen_pkg.
module census_checker
   import cen_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  pixel_type     req_pixel_value,
   input  logic          req_frame_start,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  logic [7:0]    rsp_census_code,
   input  pos_type       rsp_out_row,
   input  pos_type       rsp_out_col,
   input  logic          rsp_frame_done,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  size_type      csr_data,
   output int            error_count,
   output int            pending_codes
);

   typedef struct {
      logic [7:0] code;
      pos_type    row;
      pos_type    col;
      logic       done;
   } census_code_type;

   localparam int REPORT_LIMIT = 100;
   localparam int HEIGHT_CAP   = 4096;

   census_code_type awaited_codes[$];

   size_type  width_reg;
   size_type  height_reg;
   pixel_type upper_line [MAX_WIDTH];
   pixel_type middle_line [MAX_WIDTH];
   // top, middle, bottom rows of columns col-2 and col-1
   pixel_type window_cols [6];
   pos_type   col_pos;
   pos_type   row_pos;

   initial begin
      error_count   = 0;
      pending_codes = 0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < REPORT_LIMIT) begin
         $display("[%0t] census mismatch: %s", $time, msg);
      end
      error_count++;
   endtask

   task automatic clear_window_state();
      width_reg  = size_type'(640);
      height_reg = size_type'(480);
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      for (int i = 0; i < 6; i++) begin
         window_cols[i] = '0;
      end
      col_pos = '0;
      row_pos = '0;
   endtask

   task automatic predict_census(input pixel_type pix, input logic frame_start);
      int              w;
      int              h;
      int              c;
      int              r;
      int              slot;
      int              bit_pos;
      pixel_type       nb [3][3];
      census_code_type item;

      w = int'(width_reg);
      if (w < 3) w = 3;
      else if (w > WIDTH_CAP) w = WIDTH_CAP;
      h = int'(height_reg);
      if (h < 3) h = 3;
      else if (h > HEIGHT_CAP) h = HEIGHT_CAP;

      if (frame_start) begin
         col_pos = '0;
         row_pos = '0;
      end
      c    = int'(col_pos);
      r    = int'(row_pos);
      slot = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;

      for (int y = 0; y < 3; y++) begin
         nb[y][0] = window_cols[y*2];
         nb[y][1] = window_cols[y*2+1];
      end
      nb[0][2] = upper_line[slot];
      nb[1][2] = middle_line[slot];
      nb[2][2] = pix;
      upper_line[slot]  = nb[1][2];
      middle_line[slot] = pix;

      if (r >= 1 && c >= 1) begin
         item.code = '0;
         // centre sits at (r-1, c-1); codes on the first row or column stay zero
         if (r >= 2 && c >= 2) begin
            bit_pos = 0;
            for (int y = 0; y < 3; y++) begin
               for (int x = 0; x < 3; x++) begin
                  if (!(y == 1 && x == 1)) begin
                     if (nb[y][x] < nb[1][1]) item.code[bit_pos] = 1'b1;
                     bit_pos++;
                  end
               end
            end
         end
         item.row  = pos_type'(r - 1);
         item.col  = pos_type'(c - 1);
         item.done = (r == h - 1) && (c == w - 1);
         awaited_codes = {awaited_codes, item};
      end

      for (int y = 0; y < 3; y++) begin
         window_cols[y*2]   = nb[y][1];
         window_cols[y*2+1] = nb[y][2];
      end

      // >= so that a size shrunk mid-frame still wraps
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = pos_type'(c);
      row_pos = pos_type'(r);
   endtask

   always @(posedge clock) begin : watch
      census_code_type want;
      if (reset) begin
         clear_window_state();
         awaited_codes.delete();
         pending_codes <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_reg = csr_data;
               CSR_FRAME_HEIGHT: height_reg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_census(req_pixel_value, req_frame_start);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_codes.size() == 0) begin
               report_mismatch($sformatf("result transfer at row %0d col %0d with none expected",
                                         rsp_out_row, rsp_out_col));
            end else begin
               want = awaited_codes[0];
               awaited_codes.delete(0);
               if (rsp_census_code !== want.code) begin
                  report_mismatch($sformatf("code at row %0d col %0d: got %02h, expected %02h",
                                            want.row, want.col, rsp_census_code, want.code));
               end
               if (rsp_out_row !== want.row) begin
                  report_mismatch($sformatf("out_row: got %0d, expected %0d",
                                            rsp_out_row, want.row));
               end
               if (rsp_out_col !== want.col) begin
                  report_mismatch($sformatf("out_col at row %0d: got %0d, expected %0d",
                                            want.row, rsp_out_col, want.col));
               end
               if (rsp_frame_done !== want.done) begin
                  report_mismatch($sformatf("frame_done at row %0d col %0d: got %b, expected %b",
                                            want.row, want.col, rsp_frame_done, want.done));
               end
            end
         end
         pending_codes <= awaited_codes.size();
      end
   end

endmodule

// ----- sim/census_transform_3x3_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for census_transform_3x3: clock, reset, pixel stimulus, register writes and
// the verdict. Depends on cen_pkg, census_transform_3x3 and census_checker.
module census_transform_3x3_tb;
   import cen_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int RANDOM_PIXELS = 650;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_CYCLES  = 4;
   localparam int HEIGHT_CAP    = 4096;
   localparam int LARGE_TAIL    = 64;

   typedef enum int {
      PIX_ANY,
      PIX_NEAR,
      PIX_EXTREME
   } pixel_flavour_type;

   logic          clock            = 1'b0;
   logic          reset            = 1'b1;
   logic          req_valid        = 1'b0;
   logic          req_stall;
   pixel_type     req_pixel_value  = '0;
   logic          req_frame_start  = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall        = 1'b0;
   logic [7:0]    rsp_census_code;
   pos_type       rsp_out_row;
   pos_type       rsp_out_col;
   logic          rsp_frame_done;
   logic          csr_write_enable = 1'b0;
   csr_index_type csr_index        = CSR_FRAME_WIDTH;
   size_type      csr_data         = '0;

   int error_count;
   int pending_codes;
   int cycle_count   = 0;
   int pixels_sent   = 0;
   int cur_width     = 640;
   int hold_request  = 0;
   bit quiet_stretch = 1'b0;

   always #6 clock = ~clock;

   census_transform_3x3 u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_value  (req_pixel_value),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_census_code  (rsp_census_code),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_frame_done   (rsp_frame_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   census_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_value  (req_pixel_value),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_census_code  (rsp_census_code),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_frame_done   (rsp_frame_done),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .error_count      (error_count),
      .pending_codes    (pending_codes)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("census_transform_3x3 test failed");
         $finish;
      end
   end

   // result side: random stall before each transfer, or a long hold-off on request
   initial begin : drain_results
      int hold;
      @(negedge reset);
      forever begin
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
         end else begin
            hold = quiet_stretch ? 0 : $urandom_range(8, 0);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic int size_in_use(input size_type value, input int cap);
      int v;
      v = int'(value);
      if (v < 3) v = 3;
      else if (v > cap) v = cap;
      return v;
   endfunction

   function automatic pixel_type pick_pixel(input pixel_flavour_type flavour,
                                            input pixel_type base);
      case (flavour)
         PIX_ANY:  return pixel_type'($urandom_range(255, 0));
         PIX_NEAR: return base + pixel_type'($urandom_range(2, 0));
         default:  return ($urandom_range(1, 0) != 0) ? 8'hFF : 8'h00;
      endcase
   endfunction

   task automatic send_pixel(input pixel_type pix, input logic frame_start);
      int gap;
      gap = quiet_stretch ? 0 : $urandom_range(8, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      req_frame_start <= frame_start;
      do @(posedge clock); while (req_stall);
   endtask

   // nine pixels, first byte in the top bits
   task automatic send_block(input logic [71:0] pixels, input logic start_first);
      for (int i = 0; i < 9; i++) begin
         send_pixel(pixels[(8-i)*8 +: 8], start_first && (i == 0));
      end
   endtask

   // check pending_codes only once the checker has seen the last pixel transfer
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_codes != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_size(input size_type w, input size_type h);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_FRAME_WIDTH;
      csr_data         <= w;
      @(posedge clock);
      csr_index        <= CSR_FRAME_HEIGHT;
      csr_data         <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Whole frames plus a partial tail. A wider frame must restart at (0,0) so the
   // line stores are refilled before any code depends on them.
   task automatic run_phase(input size_type w_reg, input size_type h_reg, input int frames,
                            input int tail, input bit restart, input bit noisy);
      int                w_eff;
      int                area;
      int                total;
      logic              start;
      pixel_flavour_type flavour;
      pixel_type         base;
      wait_until_drained();
      write_frame_size(w_reg, h_reg);
      w_eff     = size_in_use(w_reg, WIDTH_CAP);
      area      = w_eff * size_in_use(h_reg, HEIGHT_CAP);
      cur_width = w_eff;
      total     = frames * area + tail;
      flavour   = pixel_flavour_type'($urandom_range(2, 0));
      base      = pixel_type'($urandom_range(255, 0));
      for (int n = 0; n < total; n++) begin
         if (n == 0) start = restart;
         else if (n % area == 0) start = $urandom_range(1, 0);
         else start = noisy && ($urandom_range(63, 0) == 0);
         send_pixel(pick_pixel(flavour, base), start);
      end
      pixels_sent += total;
   endtask

   initial begin : stimulus
      int       random_start;
      int       sel;
      size_type w;
      size_type h;
      bit       restart;
      bit       first;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sizes below the minimum clamp to 3 x 3
      wait_until_drained();
      write_frame_size(size_type'(0), size_type'(2));
      cur_width = 3;
      // bright centre in a dark ring, then a dark centre in a bright ring with no frame_start between
      send_block({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1);
      send_block({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd128}, 1'b0);
      // frame cut short by an early frame_start; ties never set a bit
      send_pixel(8'd77, 1'b1);
      send_pixel(8'd78, 1'b0);
      send_block({8'd99, 8'd101, 8'd99, 8'd101, 8'd100, 8'd99, 8'd100, 8'd101, 8'd0}, 1'b1);

      // width and height shrunk mid-frame, position past both: counters wrap
      run_phase(size_type'(8), size_type'(8), 0, 28, 1'b1, 1'b0);
      run_phase(size_type'(4), size_type'(3), 1, 5, 1'b0, 1'b0);

      first        = 1'b1;
      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         sel = $urandom_range(7, 0);
         if (sel == 0) w = size_type'($urandom_range(2, 0));
         else if (sel == 1) w = size_type'($urandom_range(40, 13));
         else w = size_type'($urandom_range(12, 3));
         sel = $urandom_range(7, 0);
         if (sel == 0) h = size_type'($urandom_range(2, 0));
         else h = size_type'($urandom_range(8, 3));
         restart = (size_in_use(w, WIDTH_CAP) > cur_width) || ($urandom_range(3, 0) != 0);
         quiet_stretch = ($urandom_range(3, 0) == 0);
         if (first) begin
            // back-pressure: results held off while pixels keep coming
            hold_request  = LONG_HOLD;
            quiet_stretch = 1'b1;
         end
         run_phase(w, h, $urandom_range(2, 1), $urandom_range(20, 0), restart, 1'b1);
         first = 1'b0;
      end

      // largest sizes: start of a frame with the all-ones width, then of the tallest frame
      quiet_stretch = 1'b0;
      run_phase(size_type'(8191), size_type'(3), 0, LARGE_TAIL, 1'b1, 1'b0);
      run_phase(size_type'(3), size_type'(4096), 0, LARGE_TAIL, 1'b1, 1'b0);

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("census_transform_3x3 test passed");
      end else begin
         $display("census_transform_3x3 test failed");
      end
      $finish;
   end

endmodule

// ----- census_transform_3x3.f -----
rtl/cen_pkg.sv
rtl/cen_line_store.sv
rtl/census_transform_3x3.sv
sim/census_checker.sv
sim/census_transform_3x3_tb.sv
